/* rtl/core/bet_pkg.sv */
// Package for the byte entropy threshold block.
// Holds widths, constants, payload structs and state encodings. No dependencies.
package bet_pkg;
    localparam int MAX_SAMPLE = 4096;
    localparam int CNT_W      = $clog2(MAX_SAMPLE + 1);
    localparam int LOG_FRAC   = 24;
    localparam int LOG_W      = LOG_FRAC + 5;
    localparam int SUM_W      = CNT_W + LOG_W;
    localparam int BIN_W      = 8;
    localparam int BINS       = 256;
    localparam logic [15:0] ENTROPY_MAX = 16'd32768;
    localparam logic [15:0] THRESH_RST  = 16'd29491;

    typedef struct packed {
        logic [7:0] sample_byte;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic [15:0] entropy_value;
        logic        above_threshold;
        logic [12:0] counted_bytes;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_UPD, ST_SCAN_RD, ST_SCAN_LOG, ST_SCAN_MUL,
        ST_TOT_LOG, ST_TOT_MUL, ST_DIV, ST_DONE
    } t_state;

    typedef struct packed {
        logic         start;
        logic [CNT_W-1:0] x;
    } t_log_req;
endpackage

/* rtl/core/byte_entropy_threshold.sv */
// Top level of the byte entropy threshold block.
// Depends on bet_pkg, bet_ram, bet_log2.
//
// Request channel: i_start with i_req (sample_byte, last_byte); a request
// is taken when i_start is high and o_busy is low.
// Each byte takes a histogram read and a write-back through one RAM.
// After a marked last byte, the block walks all 256 bins; each nonzero bin
// goes through the shared log2 unit (squaring per bit), zero bins skip it.
// Then log2 N, then a restoring divide by N. The walk also clears each bin.
// The result appears on o_rsp for one cycle with o_valid; the receiver
// cannot stall, so nothing is held back.
// Reset: a clearing pass writes zero to all 256 bins with
// o_busy high; configuration writes are taken at any time.
// i_cfg_we writes the alert threshold (Q4.12), reset value 7.2.
module byte_entropy_threshold import bet_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_valid,
    output t_rsp        o_rsp
);
    t_state            r_state, n_state;
    logic [15:0]       r_thresh;
    logic [CNT_W-1:0]  r_total;
    logic [BIN_W-1:0]  r_byte;
    logic              r_last;
    logic [BIN_W:0]    r_idx;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_whole;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W:0]    r_rem;
    logic [$clog2(SUM_W+1)-1:0] r_dcnt;
    logic              r_valid;
    t_rsp              r_rsp;

    logic              we;
    logic [BIN_W-1:0]  waddr, raddr;
    logic [CNT_W-1:0]  wdata, rdata;
    t_log_req          lreq;
    logic              ldone;
    logic [LOG_W-1:0]  lres;
    logic [CNT_W:0]    rem_sh;
    logic [16:0]       q_rnd;
    logic [15:0]       h;

    bet_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    bet_log2 u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(lreq),
        .o_done(ldone), .o_log(lres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        we         = 1'b0;
        waddr      = r_idx[BIN_W-1:0];
        wdata      = '0;
        raddr      = r_idx[BIN_W-1:0];
        lreq.start = 1'b0;
        lreq.x     = r_cnt;
        unique case (r_state)
            ST_CLEAR: begin
                we = 1'b1;
                if (r_idx[BIN_W]) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                raddr = i_req.sample_byte;
                if (i_start) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                waddr = r_byte;
                wdata = rdata + CNT_W'(1);
                we    = (r_total < CNT_W'(MAX_SAMPLE));
                n_state = r_last ? ST_SCAN_RD : ST_IDLE;
            end
            ST_SCAN_RD: begin
                n_state = r_idx[BIN_W] ? ST_TOT_LOG : ST_SCAN_LOG;
            end
            ST_SCAN_LOG: begin
                we     = 1'b1;
                lreq.x = rdata;
                if (rdata == '0) begin
                    n_state = ST_SCAN_RD;
                end else begin
                    lreq.start = 1'b1;
                    n_state = ST_SCAN_MUL;
                end
            end
            ST_SCAN_MUL: begin
                raddr = r_idx[BIN_W-1:0];
                if (ldone) begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_TOT_LOG: begin
                lreq.start = 1'b1;
                lreq.x     = r_total;
                n_state    = ST_TOT_MUL;
            end
            ST_TOT_MUL: begin
                if (ldone) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dcnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign rem_sh = {r_rem[CNT_W-1:0], r_whole[SUM_W-1]};
    assign q_rnd  = 17'(({r_quo[SUM_W-1:0]} + SUM_W'(1 << (LOG_FRAC - 13)))
                        >> (LOG_FRAC - 12));
    assign h = (q_rnd > 17'(ENTROPY_MAX)) ? ENTROPY_MAX : q_rnd[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_total  <= '0;
            r_idx    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_CLEAR: r_idx <= r_idx + 1'b1;
                ST_IDLE: begin
                    r_byte <= i_req.sample_byte;
                    r_last <= i_req.last_byte;
                    r_idx  <= '0;
                    r_sum  <= '0;
                end
                ST_UPD: begin
                    if (r_total < CNT_W'(MAX_SAMPLE)) begin
                        r_total <= r_total + CNT_W'(1);
                    end
                end
                ST_SCAN_RD: ;
                ST_SCAN_LOG: begin
                    r_cnt <= rdata;
                    r_idx <= r_idx + 1'b1;
                end
                ST_SCAN_MUL: begin
                    if (ldone) begin
                        r_sum <= r_sum + SUM_W'(r_cnt) * SUM_W'(lres);
                    end
                end
                ST_TOT_LOG: ;
                ST_TOT_MUL: ;
                ST_DIV: ;
                ST_DONE: begin
                    r_valid <= 1'b1;
                    r_rsp.entropy_value   <= h;
                    r_rsp.above_threshold <= (h > r_thresh);
                    r_rsp.counted_bytes   <= 13'(r_total);
                    r_total <= '0;
                end
                default: ;
            endcase
            if (r_state == ST_TOT_MUL && ldone) begin
                r_whole <= (SUM_W'(r_total) * SUM_W'(lres) > r_sum)
                         ? SUM_W'(r_total) * SUM_W'(lres) - r_sum : '0;
                r_rem   <= '0;
                r_quo   <= '0;
                r_dcnt  <= ($clog2(SUM_W+1))'(SUM_W - 1);
            end
            if (r_state == ST_DIV) begin
                r_whole <= r_whole << 1;
                r_dcnt  <= r_dcnt - 1'b1;
                if (rem_sh >= {1'b0, r_total}) begin
                    r_rem <= rem_sh - {1'b0, r_total};
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_SAMPLE))
        else $error("byte total above sample limit");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> $past(r_state == ST_IDLE))
        else $error("update without request");
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_DONE))
        else $error("result without done state");
    a_ent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.entropy_value <= ENTROPY_MAX))
        else $error("entropy out of range");
endmodule

/* rtl/core/bet_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read. No dependencies.
module bet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/bet_log2.sv */
// Iterative fixed-point log2: normalize, then one squaring per cycle.
// Depends on bet_pkg.
module bet_log2 import bet_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_log_req         i_req,
    output logic             o_done,
    output logic [LOG_W-1:0] o_log
);
    logic [32:0]       r_m;
    logic [LOG_W-1:0]  r_res;
    logic [4:0]        r_bit;
    logic              r_busy;
    logic              r_done;
    logic [4:0]        k;
    logic [65:0]       sq;
    logic [34:0]       sqs;

    always_comb begin
        k = '0;
        for (int i = 1; i < CNT_W; i++) begin
            if (i_req.x[i]) begin
                k = 5'(i);
            end
        end
        sq  = r_m * r_m;
        sqs = 35'(sq >> 31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_m    <= 33'(i_req.x) << (31 - k);
                r_res  <= LOG_W'(k) << LOG_FRAC;
                r_bit  <= 5'(LOG_FRAC - 1);
                r_busy <= (i_req.x != '0);
                r_done <= (i_req.x == '0);
                if (i_req.x == '0) begin
                    r_res <= '0;
                end
            end else if (r_busy) begin
                if (sqs[32]) begin
                    r_m <= sqs[33:1];
                    r_res[r_bit] <= 1'b1;
                end else begin
                    r_m <= sqs[32:0];
                end
                r_bit <= r_bit - 5'd1;
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_log  = r_res;
endmodule
